FILE: rtl/assert_macros.svh
// Assertion macros used by the top-level RTL file of the priority queue.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define SAPQ_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("sapq assertion failed");
`define SAPQ_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("sapq reset assertion failed");
`else
`define SAPQ_ASSERT(lbl, prop)
`define SAPQ_ASSERT_RST(lbl, prop)
`endif

`endif

FILE: rtl/sapq_pkg.sv
// Package: shared types and constants of the sorted-array priority queue.
package sapq_pkg;

  localparam int SAPQ_DEPTH = 8;
  localparam int VAL_W      = 32;
  localparam int CAP_W      = 4;
  localparam int CNT_W      = 4;
  localparam int APB_DW     = 32;
  localparam int APB_AW     = 3;
  localparam int REG_IDX_LSB = 2;

  localparam logic [CAP_W-1:0] CAP_RESET = 4'd8;

  localparam logic REG_CAPACITY = 1'b0;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_POP    = 1'b1;

  typedef enum logic [1:0] {
    RES_OK    = 2'd0,
    RES_FULL  = 2'd1,
    RES_EMPTY = 2'd2
  } res_t;

  typedef struct packed {
    logic insert;
    logic pop;
    logic load;
    res_t res;
  } dp_cmd_t;

endpackage

FILE: rtl/sapq_ctrl.sv
// Controller: capacity register, request handshake FSM and command decode.
module sapq_ctrl
  import sapq_pkg::*;
#(
  parameter int DEPTH = SAPQ_DEPTH,
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [APB_AW-1:0]        paddr,
  input  logic [APB_DW-1:0]        pwdata,
  output logic [APB_DW-1:0]        prdata,
  output logic                     pready,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     in_op,
  output logic                     out_valid,
  input  logic                     out_ready,
  input  logic [CW-1:0]            fill,
  output dp_cmd_t                  cmd
);

  localparam int LW = (CW > CAP_W) ? CW : CAP_W;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_HOLD = 2'b10
  } state_t;

  state_t           state_r, state_nxt;
  logic [CAP_W-1:0] capacity_r, capacity_nxt;
  logic             cfg_wr;
  logic             accept;
  logic [LW-1:0]    cap_ext, limit, fill_ext;
  logic             full, empty;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[REG_IDX_LSB] == REG_CAPACITY);
  assign capacity_nxt = cfg_wr ? pwdata[CAP_W-1:0] : capacity_r;
  assign prdata = (paddr[REG_IDX_LSB] == REG_CAPACITY) ?
                  APB_DW'(capacity_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r <= CAP_RESET;
      state_r    <= S_IDLE;
    end else begin
      capacity_r <= capacity_nxt;
      state_r    <= state_nxt;
    end
  end

  // limit = min(capacity, DEPTH)
  assign cap_ext  = LW'(capacity_r);
  assign limit    = (cap_ext > LW'(DEPTH)) ? LW'(DEPTH) : cap_ext;
  assign fill_ext = LW'(fill);
  assign full     = fill_ext >= limit;
  assign empty    = (fill == '0);

  assign out_valid = (state_r == S_HOLD);
  assign in_ready  = !out_valid || out_ready;
  assign accept    = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) state_nxt = S_HOLD;
      end
      S_HOLD: begin
        if (accept) state_nxt = S_HOLD;
        else if (out_ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd.load   = accept;
    cmd.insert = accept && (in_op == OP_INSERT) && !full;
    cmd.pop    = accept && (in_op == OP_POP) && !empty;
    if (in_op == OP_INSERT) cmd.res = full ? RES_FULL : RES_OK;
    else                    cmd.res = empty ? RES_EMPTY : RES_OK;
  end

endmodule

FILE: rtl/sapq_datapath.sv
// Datapath: descending sorted cell array, fill counter and result registers.
module sapq_datapath
  import sapq_pkg::*;
#(
  parameter int DEPTH = SAPQ_DEPTH,
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  dp_cmd_t                  cmd,
  input  logic signed [VAL_W-1:0]  in_value,
  output logic [CW-1:0]            fill,
  output logic signed [VAL_W-1:0]  out_popped_value,
  output logic [1:0]               out_status,
  output logic [CNT_W-1:0]         out_count
);

  // cell 0 holds the largest entry
  logic signed [VAL_W-1:0] cell_r   [DEPTH];
  logic signed [VAL_W-1:0] cell_nxt [DEPTH];
  logic [DEPTH-1:0]        ge;
  logic [CW-1:0]           fill_r, fill_nxt;
  logic signed [VAL_W-1:0] popped_r;
  logic [1:0]              status_r;
  logic [CNT_W-1:0]        count_r;

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      ge[i] = (CW'(i) < fill_r) && (cell_r[i] >= in_value);
    end
  end

  always_comb begin
    for (int i = 0; i < DEPTH; i++) cell_nxt[i] = cell_r[i];
    if (cmd.pop) begin
      for (int i = 0; i < DEPTH - 1; i++) cell_nxt[i] = cell_r[i + 1];
    end else if (cmd.insert) begin
      cell_nxt[0] = ge[0] ? cell_r[0] : in_value;
      for (int i = 1; i < DEPTH; i++) begin
        if (ge[i])          cell_nxt[i] = cell_r[i];
        else if (ge[i - 1]) cell_nxt[i] = in_value;
        else                cell_nxt[i] = cell_r[i - 1];
      end
    end
  end

  always_comb begin
    fill_nxt = fill_r;
    if (cmd.insert)   fill_nxt = fill_r + 1'b1;
    else if (cmd.pop) fill_nxt = fill_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else begin
      fill_r <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.insert || cmd.pop) begin
      for (int i = 0; i < DEPTH; i++) cell_r[i] <= cell_nxt[i];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      popped_r <= cmd.pop ? cell_r[0] : '0;
      status_r <= cmd.res;
      count_r  <= CNT_W'(fill_nxt);
    end
  end

  assign fill             = fill_r;
  assign out_popped_value = popped_r;
  assign out_status       = status_r;
  assign out_count        = count_r;

endmodule

FILE: rtl/sorted_array_priority_queue.sv
// Top level: bounded priority queue on a sorted register array.
// Results are registered: a request accepted in a cycle has its result valid in the following cycle.
// Throughput: one request per cycle while out_ready stays high; all cells compare in parallel.
// in_ready drops only while a result waits and out_ready is low.
// Reset (rst_n low, synchronous): queue empty, capacity 8, no result pending.
// Entry contents are not cleared; only stored entries are ever read.
`include "assert_macros.svh"

module sorted_array_priority_queue
  import sapq_pkg::*;
#(
  parameter int DEPTH = SAPQ_DEPTH
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [APB_AW-1:0]        paddr,
  input  logic [APB_DW-1:0]        pwdata,
  output logic [APB_DW-1:0]        prdata,
  output logic                     pready,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     in_op,
  input  logic signed [VAL_W-1:0]  in_value,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [VAL_W-1:0]  out_popped_value,
  output logic [1:0]               out_status,
  output logic [CNT_W-1:0]         out_count
);

  localparam int CW = $clog2(DEPTH + 1);

  dp_cmd_t       cmd;
  logic [CW-1:0] fill;

  sapq_ctrl #(.DEPTH(DEPTH)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_op     (in_op),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .fill      (fill),
    .cmd       (cmd)
  );

  sapq_datapath #(.DEPTH(DEPTH)) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .in_value         (in_value),
    .fill             (fill),
    .out_popped_value (out_popped_value),
    .out_status       (out_status),
    .out_count        (out_count)
  );

  `SAPQ_ASSERT(a_fill_bound, fill <= CW'(DEPTH))
  `SAPQ_ASSERT(a_pop_ok, (in_valid && in_ready && in_op == OP_POP && fill != '0) |=> (out_valid && out_status == RES_OK && fill == $past(fill) - 1'b1))
  `SAPQ_ASSERT(a_err_zero, (out_valid && out_status != RES_OK) |-> (out_popped_value == '0))
  `SAPQ_ASSERT_RST(a_reset_empty, !rst_n |=> (fill == '0 && !out_valid))

endmodule

FILE: bench/tb_sorted_array_priority_queue.sv
// Testbench of the sorted-array priority queue: table-driven and random requests vs. a predictor.
module tb_sorted_array_priority_queue;
  import sapq_pkg::*;

  localparam int QDEPTH      = SAPQ_DEPTH;
  localparam int CYCLE_LIMIT = 400000;
  localparam int MAX_REPORTS = 10;
  localparam int PHASE_ITEMS = 181;
  localparam int SCRIPT_LEN  = 22;
  localparam int NUM_PHASES  = 9;
  localparam int REG_UNUSED_IDX = 1;
  localparam logic [APB_AW-1:0] CAP_ADDR   = APB_AW'(REG_CAPACITY) << REG_IDX_LSB;
  localparam logic [APB_AW-1:0] SPARE_ADDR = APB_AW'(REG_UNUSED_IDX << REG_IDX_LSB);

  typedef struct packed {
    logic [VAL_W-1:0] popped;
    res_t             status;
    logic [CNT_W-1:0] count;
  } qresult_t;

  typedef struct packed {
    logic             op;
    logic [VAL_W-1:0] value;
    bit               typed;
    qresult_t         res;
  } script_row_t;

  typedef struct packed {
    logic [APB_DW-1:0] cap_data;
    bit                spare_write;
    bit                calm;
    logic [6:0]        insert_pct;
  } phase_t;

  // directed requests; typed rows carry their own expected result
  localparam script_row_t SCRIPT [SCRIPT_LEN] = '{
    '{OP_POP,    32'h0000_0000, 1'b1, '{32'h0, RES_EMPTY, 4'd0}},
    '{OP_POP,    32'hFFFF_FFFF, 1'b1, '{32'h0, RES_EMPTY, 4'd0}},
    '{OP_INSERT, 32'h7FFF_FFFF, 1'b1, '{32'h0, RES_OK, 4'd1}},
    '{OP_INSERT, 32'h8000_0000, 1'b1, '{32'h0, RES_OK, 4'd2}},
    '{OP_INSERT, 32'hFFFF_FFFF, 1'b0, '0},
    '{OP_INSERT, 32'h0000_0000, 1'b0, '0},
    '{OP_INSERT, 32'h0000_0001, 1'b0, '0},
    '{OP_INSERT, 32'h0000_0005, 1'b0, '0},
    '{OP_INSERT, 32'h0000_0005, 1'b0, '0},
    '{OP_INSERT, 32'h8000_0000, 1'b0, '0},
    '{OP_INSERT, 32'h0000_0003, 1'b1, '{32'h0, RES_FULL, 4'd8}},
    '{OP_POP,    32'hAAAA_5555, 1'b1, '{32'h7FFF_FFFF, RES_OK, 4'd7}},
    '{OP_POP,    32'h5555_AAAA, 1'b0, '0},
    '{OP_POP,    32'h0000_0000, 1'b0, '0},
    '{OP_INSERT, 32'h0000_0005, 1'b0, '0},
    '{OP_POP,    32'h0000_0000, 1'b0, '0},
    '{OP_POP,    32'h0000_0000, 1'b0, '0},
    '{OP_POP,    32'h0000_0000, 1'b0, '0},
    '{OP_POP,    32'h0000_0000, 1'b0, '0},
    '{OP_POP,    32'h0000_0000, 1'b0, '0},
    '{OP_POP,    32'h0000_0000, 1'b1, '{32'h8000_0000, RES_OK, 4'd0}},
    '{OP_POP,    32'hFFFF_FFFF, 1'b1, '{32'h0, RES_EMPTY, 4'd0}}
  };

  // capacity per phase: above depth, zero, lowered below count, junk in upper bits
  localparam phase_t PHASES [NUM_PHASES] = '{
    '{32'h0000_0008, 1'b0, 1'b0, 7'd70},
    '{32'h0000_0003, 1'b0, 1'b0, 7'd40},
    '{32'hFFFF_FFFF, 1'b0, 1'b1, 7'd75},
    '{32'h1234_5671, 1'b0, 1'b0, 7'd50},
    '{32'h0000_0000, 1'b0, 1'b0, 7'd60},
    '{32'h0000_000C, 1'b1, 1'b0, 7'd55},
    '{32'h0000_0005, 1'b0, 1'b0, 7'd50},
    '{32'hABCD_0002, 1'b0, 1'b0, 7'd45},
    '{32'h0000_0008, 1'b0, 1'b0, 7'd55}
  };

  logic                    clk      = 1'b0;
  logic                    rst_n    = 1'b0;
  logic                    psel     = 1'b0;
  logic                    penable  = 1'b0;
  logic                    pwrite   = 1'b0;
  logic [APB_AW-1:0]       paddr    = '0;
  logic [APB_DW-1:0]       pwdata   = '0;
  logic [APB_DW-1:0]       prdata;
  logic                    pready;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic                    in_op    = OP_INSERT;
  logic signed [VAL_W-1:0] in_value = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic signed [VAL_W-1:0] out_popped_value;
  logic [1:0]              out_status;
  logic [CNT_W-1:0]        out_count;

  logic signed [VAL_W-1:0] held_vals [$];
  logic [CAP_W-1:0]        cap_setting = CAP_RESET;
  qresult_t                pending_results [$];
  int unsigned             mismatches = 0;
  int unsigned             cycles = 0;
  bit                      calm_run = 1'b0;

  sorted_array_priority_queue dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_op            (in_op),
    .in_value         (in_value),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_popped_value (out_popped_value),
    .out_status       (out_status),
    .out_count        (out_count)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic bit take_idle();
    return !calm_run && ($urandom_range(99) < 38);
  endfunction

  function automatic logic [VAL_W-1:0] rand_value();
    case ($urandom_range(3))
      0: return $urandom_range(8) - 32'd4;
      1: begin
        case ($urandom_range(3))
          0: return 32'h8000_0000;
          1: return 32'h7FFF_FFFF;
          2: return 32'hFFFF_FFFF;
          default: return 32'h0;
        endcase
      end
      default: return $urandom();
    endcase
  endfunction

  function automatic void note_mismatch(string what, logic [VAL_W-1:0] exp_v,
                                        logic [VAL_W-1:0] got_v);
    if (mismatches < MAX_REPORTS) begin
      $display("mismatch %s: expected %h, got %h", what, exp_v, got_v);
    end
    mismatches++;
  endfunction

  // applies one request to the predicted queue contents
  function automatic qresult_t apply_to_queue(logic op, logic signed [VAL_W-1:0] v);
    qresult_t r;
    int       lim;
    int       pos;
    r.popped = '0;
    r.status = RES_OK;
    lim = (int'(cap_setting) > QDEPTH) ? QDEPTH : int'(cap_setting);
    if (op == OP_INSERT) begin
      if (held_vals.size() >= lim) begin
        r.status = RES_FULL;
      end else begin
        pos = held_vals.size();
        while (pos > 0 && v < held_vals[pos-1]) pos--;
        held_vals.insert(pos, v);
      end
    end else if (held_vals.size() == 0) begin
      r.status = RES_EMPTY;
    end else begin
      r.popped = held_vals.pop_back();
    end
    r.count = CNT_W'(held_vals.size());
    return r;
  endfunction

  task automatic send_request(input logic op, input logic [VAL_W-1:0] v, input bit typed,
                              input qresult_t typed_res);
    qresult_t predicted;
    while (take_idle()) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_op    <= op;
    in_value <= v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predicted = apply_to_queue(op, v);
    pending_results.push_back(typed ? typed_res : predicted);
  endtask

  task automatic apb_access(input logic wr, input logic [APB_AW-1:0] addr,
                            input logic [APB_DW-1:0] data, output logic [APB_DW-1:0] rd);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rd = prdata;
  endtask

  task automatic set_capacity(input logic [APB_DW-1:0] data, input bit spare_write);
    logic [APB_DW-1:0] rd;
    apb_access(1'b1, CAP_ADDR, data, rd);
    cap_setting = data[CAP_W-1:0];
    // unmapped register must not touch capacity
    if (spare_write) apb_access(1'b1, SPARE_ADDR, ~data, rd);
    apb_access(1'b0, CAP_ADDR, '0, rd);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (rd[CAP_W-1:0] !== cap_setting) begin
      note_mismatch("capacity readback", cap_setting, rd[CAP_W-1:0]);
    end
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  always @(posedge clk) begin : result_check
    qresult_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          note_mismatch("result without request", '0, out_popped_value);
        end else begin
          want = pending_results.pop_front();
          if (out_popped_value !== want.popped) begin
            note_mismatch("popped_value", want.popped, out_popped_value);
          end
          if (out_status !== want.status) begin
            note_mismatch("status", want.status, out_status);
          end
          if (out_count !== want.count) begin
            note_mismatch("count", want.count, out_count);
          end
        end
      end
      out_ready <= !take_idle();
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    for (int i = 0; i < SCRIPT_LEN; i++) begin
      send_request(SCRIPT[i].op, SCRIPT[i].value, SCRIPT[i].typed, SCRIPT[i].res);
    end
    for (int p = 0; p < NUM_PHASES; p++) begin
      settle();
      set_capacity(PHASES[p].cap_data, PHASES[p].spare_write);
      calm_run = PHASES[p].calm;
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        send_request(($urandom_range(99) < PHASES[p].insert_pct) ? OP_INSERT : OP_POP,
                     rand_value(), 1'b0, '0);
      end
      calm_run = 1'b0;
    end
    settle();
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+rtl
rtl/sapq_pkg.sv
rtl/sapq_ctrl.sv
rtl/sapq_datapath.sv
rtl/sorted_array_priority_queue.sv
bench/tb_sorted_array_priority_queue.sv
